/* design/c2d_pkg.sv */
// Shared opcodes, register indexes, widths and controller/datapath bundles.
package c2d_pkg;

   localparam int unsigned ADDR_W     = 12;
   localparam int unsigned VAL_W      = 8;
   localparam int unsigned ACC_W      = 32;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 7;

   localparam logic [1:0] OP_WR_ACT = 2'd0;
   localparam logic [1:0] OP_WR_WGT = 2'd1;
   localparam logic [1:0] OP_RUN    = 2'd2;
   localparam logic [1:0] OP_RD_OUT = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_IN_CHANNELS  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IN_HEIGHT    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_IN_WIDTH     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_CHANNELS = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_KERNEL_ROWS  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_KERNEL_COLS  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_SIZE    = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_PAD_AMOUNT   = 3'd7;

   typedef struct packed {
      logic wr_act;
      logic wr_wgt;
      logic rd_out;
      logic run_start;
      logic div_step;
      logic mul1;
      logic mul2;
      logic mul3;
      logic run_init;
      logic run_step;
      logic rsp_load;
      logic rsp_read;
      logic rsp_err;
   } c2d_cmd_type;

   typedef struct packed {
      logic shape_err;
      logic geo_err;
      logic div_done;
      logic run_last;
   } c2d_sts_type;

endpackage

/* design/c2d_if.sv */
// Request and response channel interfaces.
interface c2d_req_if;
   logic                              valid;
   logic                              ready;
   logic [1:0]                        op;
   logic [c2d_pkg::ADDR_W-1:0]        addr;
   logic signed [c2d_pkg::VAL_W-1:0]  value;
   modport source (output valid, op, addr, value, input ready);
   modport sink (input valid, op, addr, value, output ready);
endinterface

interface c2d_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [c2d_pkg::ACC_W-1:0]  read_value;
   logic                              status;
   modport source (output valid, read_value, status, input ready);
   modport sink (input valid, read_value, status, output ready);
endinterface

/* design/c2d_ctrl.sv */
// Controller state machine: item decode, geometry check sequence, run and response.
module c2d_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic [1:0]           req_op,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  c2d_pkg::c2d_sts_type sts,
   output c2d_pkg::c2d_cmd_type cmd
);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_READ  = 4'd1;
   localparam logic [3:0] S_DIV   = 4'd2;
   localparam logic [3:0] S_MUL1  = 4'd3;
   localparam logic [3:0] S_MUL2  = 4'd4;
   localparam logic [3:0] S_MUL3  = 4'd5;
   localparam logic [3:0] S_CHECK = 4'd6;
   localparam logic [3:0] S_RUN   = 4'd7;
   localparam logic [3:0] S_DRAIN = 4'd8;

   logic [3:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       xfer;

   assign req_ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign xfer      = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (xfer) begin
               unique case (req_op)
                  c2d_pkg::OP_WR_ACT: begin
                     cmd.wr_act   = 1'b1;
                     cmd.rsp_load = 1'b1;
                  end
                  c2d_pkg::OP_WR_WGT: begin
                     cmd.wr_wgt   = 1'b1;
                     cmd.rsp_load = 1'b1;
                  end
                  c2d_pkg::OP_RUN: begin
                     cmd.run_start = 1'b1;
                     state_in      = S_DIV;
                  end
                  default: begin
                     cmd.rd_out = 1'b1;
                     state_in   = S_READ;
                  end
               endcase
            end
         end
         S_READ: begin
            cmd.rsp_load = 1'b1;
            cmd.rsp_read = 1'b1;
            state_in     = S_IDLE;
         end
         S_DIV: begin
            if (sts.shape_err) begin
               cmd.rsp_load = 1'b1;
               cmd.rsp_err  = 1'b1;
               state_in     = S_IDLE;
            end else if (sts.div_done) begin
               state_in = S_MUL1;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         S_MUL1: begin
            cmd.mul1 = 1'b1;
            state_in = S_MUL2;
         end
         S_MUL2: begin
            cmd.mul2 = 1'b1;
            state_in = S_MUL3;
         end
         S_MUL3: begin
            cmd.mul3 = 1'b1;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (sts.geo_err) begin
               cmd.rsp_load = 1'b1;
               cmd.rsp_err  = 1'b1;
               state_in     = S_IDLE;
            end else begin
               cmd.run_init = 1'b1;
               state_in     = S_RUN;
            end
         end
         S_RUN: begin
            cmd.run_step = 1'b1;
            if (sts.run_last) state_in = S_DRAIN;
         end
         S_DRAIN: begin
            // last sum is written to the output store at this edge
            cmd.rsp_load = 1'b1;
            state_in     = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      if (cmd.rsp_load) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

/* design/c2d_datapath.sv */
// Datapath: registers, stores, geometry arithmetic, address walk and MAC.
module c2d_datapath #(
   parameter int unsigned ACT_DEPTH    = 4096,
   parameter int unsigned WEIGHT_DEPTH = 4096,
   parameter int unsigned OUT_DEPTH    = 4096
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  c2d_pkg::c2d_cmd_type                   cmd,
   output c2d_pkg::c2d_sts_type                   sts,
   input  logic [c2d_pkg::ADDR_W-1:0]             req_addr,
   input  logic signed [c2d_pkg::VAL_W-1:0]       req_value,
   input  logic                                   csr_we,
   input  logic [c2d_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [c2d_pkg::CSR_DATA_W-1:0]         csr_wdata,
   output logic signed [c2d_pkg::ACC_W-1:0]       read_value,
   output logic                                   status
);

   localparam int unsigned AAW = $clog2(ACT_DEPTH);
   localparam int unsigned WAW = $clog2(WEIGHT_DEPTH);
   localparam int unsigned OAW = $clog2(OUT_DEPTH);

   // configuration registers
   logic [6:0] cin_ff, h_ff, w_ff, cout_ff;
   logic [3:0] kr_ff, kc_ff, s_ff;
   logic [2:0] p_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cin_ff  <= 7'd1;
         h_ff    <= 7'd1;
         w_ff    <= 7'd1;
         cout_ff <= 7'd1;
         kr_ff   <= 4'd1;
         kc_ff   <= 4'd1;
         s_ff    <= 4'd1;
         p_ff    <= 3'd0;
      end else if (csr_we) begin
         unique case (csr_index)
            c2d_pkg::CSR_IN_CHANNELS:  cin_ff  <= csr_wdata;
            c2d_pkg::CSR_IN_HEIGHT:    h_ff    <= csr_wdata;
            c2d_pkg::CSR_IN_WIDTH:     w_ff    <= csr_wdata;
            c2d_pkg::CSR_OUT_CHANNELS: cout_ff <= csr_wdata;
            c2d_pkg::CSR_KERNEL_ROWS:  kr_ff   <= csr_wdata[3:0];
            c2d_pkg::CSR_KERNEL_COLS:  kc_ff   <= csr_wdata[3:0];
            c2d_pkg::CSR_STEP_SIZE:    s_ff    <= csr_wdata[3:0];
            c2d_pkg::CSR_PAD_AMOUNT:   p_ff    <= csr_wdata[2:0];
            default: ;
         endcase
      end
   end

   // output size by repeated subtraction of the stride
   logic signed [8:0] rem_h_start, rem_w_start, rem_h_ff, rem_w_ff, s9;
   logic [7:0]        qh_ff, qw_ff, ho, wo;
   logic              zero_err, zero_err_ff;

   assign rem_h_start = $signed({2'b0, h_ff}) + $signed({5'b0, p_ff, 1'b0})
                        - $signed({5'b0, kr_ff});
   assign rem_w_start = $signed({2'b0, w_ff}) + $signed({5'b0, p_ff, 1'b0})
                        - $signed({5'b0, kc_ff});
   assign s9 = $signed({5'b0, s_ff});
   assign zero_err = (cin_ff == 7'd0) || (h_ff == 7'd0) || (w_ff == 7'd0) ||
                     (cout_ff == 7'd0) || (kr_ff == 4'd0) || (kc_ff == 4'd0) ||
                     (s_ff == 4'd0) || (rem_h_start < 0) || (rem_w_start < 0);
   assign ho = qh_ff + 8'd1;
   assign wo = qw_ff + 8'd1;

   always_ff @(posedge clock) begin
      if (cmd.run_start) begin
         rem_h_ff    <= rem_h_start;
         rem_w_ff    <= rem_w_start;
         qh_ff       <= 8'd0;
         qw_ff       <= 8'd0;
         zero_err_ff <= zero_err;
      end else if (cmd.div_step) begin
         if (rem_h_ff >= s9) begin
            rem_h_ff <= rem_h_ff - s9;
            qh_ff    <= qh_ff + 8'd1;
         end
         if (rem_w_ff >= s9) begin
            rem_w_ff <= rem_w_ff - s9;
            qw_ff    <= qw_ff + 8'd1;
         end
      end
   end

   // store sizes and walk increments, one multiply layer per step
   logic [13:0] hw_ff;
   logic [7:0]  kk_ff;
   logic [15:0] howo_ff;
   logic [10:0] sw_ff;
   logic [9:0]  pw_ff;
   logic [20:0] act_sz_ff;
   logic [14:0] cikk_ff;
   logic [21:0] wsz_ff;
   logic [22:0] osz_ff;

   always_ff @(posedge clock) begin
      if (cmd.mul1) begin
         hw_ff   <= 14'(h_ff) * 14'(w_ff);
         kk_ff   <= 8'(kr_ff) * 8'(kc_ff);
         howo_ff <= 16'(ho) * 16'(wo);
         sw_ff   <= 11'(s_ff) * 11'(w_ff);
         pw_ff   <= 10'(p_ff) * 10'(w_ff);
      end
      if (cmd.mul2) begin
         act_sz_ff <= 21'(cin_ff) * 21'(hw_ff);
         cikk_ff   <= 15'(cin_ff) * 15'(kk_ff);
      end
      if (cmd.mul3) begin
         wsz_ff <= 22'(cout_ff) * 22'(cikk_ff);
         osz_ff <= 23'(cout_ff) * 23'(howo_ff);
      end
   end

   // convolution walk
   logic [6:0]         co_ff, ci_ff;
   logic [7:0]         oh_ff, ow_ff;
   logic [3:0]         kh_ff, kw_ff;
   logic signed [12:0] ih_base_ff, iw_base_ff, ih_cur_ff, iw_cur_ff, neg_p, s13;
   logic signed [21:0] ihb_w_ff, ihw_cur_ff, neg_pw;
   logic [20:0]        a_ch_ff;
   logic [21:0]        wi_ff, wco_ff;
   logic [22:0]        oaddr_ff;
   logic signed [23:0] ai;
   logic               last_kw, last_kh, last_ci, last_ow, last_oh, last_co;
   logic               tap_last, in_bounds;

   assign neg_p  = 13'sd0 - $signed({10'b0, p_ff});
   assign neg_pw = 22'sd0 - $signed({12'b0, pw_ff});
   assign s13    = $signed({9'b0, s_ff});

   assign last_kw  = (kw_ff == kc_ff - 4'd1);
   assign last_kh  = (kh_ff == kr_ff - 4'd1);
   assign last_ci  = (ci_ff == cin_ff - 7'd1);
   assign last_ow  = (ow_ff == wo - 8'd1);
   assign last_oh  = (oh_ff == ho - 8'd1);
   assign last_co  = (co_ff == cout_ff - 7'd1);
   assign tap_last = last_kw && last_kh && last_ci;

   assign ai = $signed({3'b0, a_ch_ff}) + 24'(ihw_cur_ff) + 24'(iw_cur_ff);
   assign in_bounds = !ih_cur_ff[12] && (ih_cur_ff < $signed({6'b0, h_ff})) &&
                      !iw_cur_ff[12] && (iw_cur_ff < $signed({6'b0, w_ff}));

   always_ff @(posedge clock) begin
      if (cmd.run_init) begin
         co_ff      <= '0;
         ci_ff      <= '0;
         oh_ff      <= '0;
         ow_ff      <= '0;
         kh_ff      <= '0;
         kw_ff      <= '0;
         ih_base_ff <= neg_p;
         iw_base_ff <= neg_p;
         ih_cur_ff  <= neg_p;
         iw_cur_ff  <= neg_p;
         ihb_w_ff   <= neg_pw;
         ihw_cur_ff <= neg_pw;
         a_ch_ff    <= '0;
         wi_ff      <= '0;
         wco_ff     <= '0;
         oaddr_ff   <= '0;
      end else if (cmd.run_step) begin
         if (!last_kw) begin
            kw_ff     <= kw_ff + 4'd1;
            iw_cur_ff <= iw_cur_ff + 13'sd1;
         end else begin
            kw_ff     <= '0;
            iw_cur_ff <= iw_base_ff;
            if (!last_kh) begin
               kh_ff      <= kh_ff + 4'd1;
               ih_cur_ff  <= ih_cur_ff + 13'sd1;
               ihw_cur_ff <= ihw_cur_ff + $signed({15'b0, w_ff});
            end else begin
               kh_ff <= '0;
               if (!last_ci) begin
                  ci_ff      <= ci_ff + 7'd1;
                  a_ch_ff    <= a_ch_ff + 21'(hw_ff);
                  ih_cur_ff  <= ih_base_ff;
                  ihw_cur_ff <= ihb_w_ff;
               end else begin
                  ci_ff    <= '0;
                  a_ch_ff  <= '0;
                  oaddr_ff <= oaddr_ff + 23'd1;
                  if (!last_ow) begin
                     ow_ff      <= ow_ff + 8'd1;
                     iw_base_ff <= iw_base_ff + s13;
                     iw_cur_ff  <= iw_base_ff + s13;
                     ih_cur_ff  <= ih_base_ff;
                     ihw_cur_ff <= ihb_w_ff;
                  end else begin
                     ow_ff      <= '0;
                     iw_base_ff <= neg_p;
                     iw_cur_ff  <= neg_p;
                     if (!last_oh) begin
                        oh_ff      <= oh_ff + 8'd1;
                        ih_base_ff <= ih_base_ff + s13;
                        ih_cur_ff  <= ih_base_ff + s13;
                        ihb_w_ff   <= ihb_w_ff + $signed({11'b0, sw_ff});
                        ihw_cur_ff <= ihb_w_ff + $signed({11'b0, sw_ff});
                     end else begin
                        oh_ff      <= '0;
                        ih_base_ff <= neg_p;
                        ih_cur_ff  <= neg_p;
                        ihb_w_ff   <= neg_pw;
                        ihw_cur_ff <= neg_pw;
                        co_ff      <= co_ff + 7'd1;
                     end
                  end
               end
            end
         end
         // weights of one filter are contiguous; restart or move to the next filter
         if (!tap_last) begin
            wi_ff <= wi_ff + 22'd1;
         end else if (last_ow && last_oh) begin
            wco_ff <= wco_ff + 22'(cikk_ff);
            wi_ff  <= wco_ff + 22'(cikk_ff);
         end else begin
            wi_ff <= wco_ff;
         end
      end
   end

   // stores
   logic [7:0]  act_mem [ACT_DEPTH];
   logic [7:0]  wgt_mem [WEIGHT_DEPTH];
   logic [31:0] out_mem [OUT_DEPTH];
   logic [7:0]  act_q_ff, wgt_q_ff;
   logic [31:0] out_q_ff;
   logic        act_ok, wgt_ok, out_ok, rd_ok_ff;

   assign act_ok = 32'(req_addr) < 32'(ACT_DEPTH);
   assign wgt_ok = 32'(req_addr) < 32'(WEIGHT_DEPTH);
   assign out_ok = 32'(req_addr) < 32'(OUT_DEPTH);

   always_ff @(posedge clock) begin
      if (cmd.wr_act && act_ok) act_mem[AAW'(req_addr)] <= req_value;
      act_q_ff <= act_mem[ai[AAW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_wgt && wgt_ok) wgt_mem[WAW'(req_addr)] <= req_value;
      wgt_q_ff <= wgt_mem[wi_ff[WAW-1:0]];
   end

   // MAC stage behind the store reads
   logic              s1_v_ff, s1_in_ff, s1_last_ff;
   logic [22:0]       s1_oaddr_ff;
   logic signed [15:0] prod;
   logic signed [31:0] acc_ff, mac_sum;

   assign prod    = $signed(act_q_ff) * $signed(wgt_q_ff);
   assign mac_sum = acc_ff + (s1_in_ff ? 32'(prod) : 32'sd0);

   always_ff @(posedge clock) begin
      if (reset) s1_v_ff <= 1'b0;
      else       s1_v_ff <= cmd.run_step;
   end

   always_ff @(posedge clock) begin
      s1_in_ff    <= in_bounds;
      s1_last_ff  <= tap_last;
      s1_oaddr_ff <= oaddr_ff;
      if (cmd.run_init) begin
         acc_ff <= '0;
      end else if (s1_v_ff) begin
         acc_ff <= s1_last_ff ? 32'sd0 : mac_sum;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_v_ff && s1_last_ff) out_mem[s1_oaddr_ff[OAW-1:0]] <= mac_sum;
      out_q_ff <= out_mem[OAW'(req_addr)];
      if (cmd.rd_out) rd_ok_ff <= out_ok;
   end

   // response payload
   logic signed [31:0] read_value_ff;
   logic               status_ff;

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         read_value_ff <= (cmd.rsp_read && rd_ok_ff) ? $signed(out_q_ff) : 32'sd0;
         status_ff     <= cmd.rsp_err;
      end
   end

   assign read_value = read_value_ff;
   assign status     = status_ff;

   assign sts.shape_err = zero_err_ff;
   assign sts.div_done  = (rem_h_ff < s9) && (rem_w_ff < s9);
   assign sts.geo_err   = zero_err_ff || (32'(act_sz_ff) > 32'(ACT_DEPTH)) ||
                          (32'(wsz_ff) > 32'(WEIGHT_DEPTH)) ||
                          (32'(osz_ff) > 32'(OUT_DEPTH));
   assign sts.run_last  = tap_last && last_ow && last_oh && last_co;

endmodule

/* design/conv2d_stride_pad_engine.sv */
// Direct multichannel 2D convolution engine with stride and zero padding.
// Activation and weight writes are answered directly from the idle state; an output
// read goes through S_READ, since the output store's read data is registered before
// the response is loaded. A run first sizes the output by subtracting the stride once
// per cycle, then forms the store-size products in S_MUL1, S_MUL2 and S_MUL3 and
// checks them in S_CHECK, then feeds the Co*Ho*Wo*Ci*Kh*Kw multiply-accumulates
// through one read port of each store and drains the last sum in S_DRAIN.
// A zero size or a kernel larger than the padded input is answered from the
// first sizing state; a tensor too large for its store is answered from the
// check. One item is in work at a time; the next is taken once its response
// register is free.
module conv2d_stride_pad_engine #(
   parameter int unsigned ACT_DEPTH    = 4096,
   parameter int unsigned WEIGHT_DEPTH = 4096,
   parameter int unsigned OUT_DEPTH    = 4096
) (
   input  logic                                clock,
   input  logic                                reset,
   c2d_req_if.sink                             req_ch,
   c2d_rsp_if.source                           rsp_ch,
   input  logic                                csr_we,
   input  logic [c2d_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [c2d_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   c2d_pkg::c2d_cmd_type cmd;
   c2d_pkg::c2d_sts_type sts;

   c2d_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_op    (req_ch.op),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   c2d_datapath #(
      .ACT_DEPTH    (ACT_DEPTH),
      .WEIGHT_DEPTH (WEIGHT_DEPTH),
      .OUT_DEPTH    (OUT_DEPTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_addr   (req_ch.addr),
      .req_value  (req_ch.value),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .read_value (rsp_ch.read_value),
      .status     (rsp_ch.status)
   );

`ifndef SYNTHESIS
   a_write_answers_next: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready &&
       (req_ch.op == c2d_pkg::OP_WR_ACT || req_ch.op == c2d_pkg::OP_WR_WGT))
      |=> (rsp_ch.valid && rsp_ch.read_value == 32'sd0 && !rsp_ch.status))
      else $error("write transfer not answered with a zero response");

   a_run_not_immediate: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready && req_ch.op == c2d_pkg::OP_RUN)
      |=> !rsp_ch.valid)
      else $error("run answered before geometry check");

   a_error_zero_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.status) |-> (rsp_ch.read_value == 32'sd0))
      else $error("geometry error response carries a value");

   a_step_holds_off_items: assert property (@(posedge clock) disable iff (reset)
      (cmd.run_step || cmd.div_step) |-> !req_ch.ready)
      else $error("item taken while a run is in progress");
`endif

endmodule
